// ===== design/wdce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdce_pkg
// shared types and constants of the wav data chunk extractor
// ----------------------------------------------------------------------------
package wdce_pkg;

	// ascii four-character codes, first byte in the top bits
	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;

	// file header is 12 bytes, chunk header 8
	localparam logic [3:0] HDR_LEN       = 4'd12;
	localparam logic [3:0] HDR_LAST      = 4'd11;
	localparam logic [2:0] CHUNK_HDR_LAST = 3'd7;

	// end status codes
	localparam logic [1:0] ST_COMPLETE = 2'd0;
	localparam logic [1:0] ST_TRUNC    = 2'd1;
	localparam logic [1:0] ST_PASS     = 2'd2;
	localparam logic [1:0] ST_NODATA   = 2'd3;

	// result kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// parser phase
	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_PASS   = 6'b000010,
		PH_CHUNK  = 6'b000100,
		PH_SKIP   = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	// one queued command: optional header replay or one byte, then optional end
	typedef struct packed {
		logic       replay;
		logic [3:0] cnt;
		logic       has_byte;
		logic [7:0] data;
		logic       has_end;
		logic [1:0] status;
	} cmd_t;

	// back to front: held byte read index and end of a replay
	typedef struct packed {
		logic       replay_done;
		logic [3:0] rd_idx;
	} bk_ctl_t;

endpackage

// ===== design/wdce_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdce_queue
// small command queue between the parser and the output sequencer
// ----------------------------------------------------------------------------
module wdce_queue import wdce_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

// ===== design/wdce_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdce_front
// accepts file bytes, walks the riff chunk structure, queues commands
// ----------------------------------------------------------------------------
module wdce_front import wdce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       q_push,
	output cmd_t       q_cmd,
	input  logic       q_full,
	input  bk_ctl_t    bk,
	output logic [7:0] held_data
);

	phase_t      phase_q, phase_d;
	logic [7:0]  held_q [12];
	logic [3:0]  held_cnt_q, held_cnt_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] id_q, id_d;
	logic [31:0] size_q, size_d;
	logic [31:0] rem_q, rem_d;
	logic        pad_q, pad_d;
	logic        busy_q;
	logic        acc, held_we, hdr_ok;
	logic [31:0] rem_dec;
	cmd_t        cmd;

	assign in_ready  = !q_full && !((phase_q == PH_HEADER) && busy_q);
	assign acc       = in_valid && in_ready;
	assign held_data = held_q[bk.rd_idx];
	assign rem_dec   = rem_q - 32'd1;
	assign hdr_ok    = ({held_q[0], held_q[1], held_q[2], held_q[3]} == ID_RIFF) &&
	                   ({held_q[8], held_q[9], held_q[10], in_byte} == ID_WAVE);

	always_comb begin
		phase_d    = phase_q;
		held_cnt_d = held_cnt_q;
		hdr_cnt_d  = hdr_cnt_q;
		id_d       = id_q;
		size_d     = size_q;
		rem_d      = rem_q;
		pad_d      = pad_q;
		held_we    = 1'b0;
		cmd        = '0;
		cmd.data   = in_byte;
		cmd.status = ST_NODATA;
		unique case (phase_q)
			PH_HEADER: begin
				held_we = 1'b1;
				if (held_cnt_q == HDR_LAST) begin
					held_cnt_d = '0;
					if (hdr_ok) begin
						phase_d = PH_CHUNK;
					end else begin
						cmd.replay = 1'b1;
						cmd.cnt    = HDR_LEN;
						cmd.status = ST_PASS;
						phase_d    = PH_PASS;
					end
				end else begin
					held_cnt_d = held_cnt_q + 4'd1;
					if (in_last) begin
						// short file
						cmd.replay = 1'b1;
						cmd.cnt    = held_cnt_q + 4'd1;
						cmd.status = ST_PASS;
					end
				end
			end
			PH_PASS: begin
				cmd.has_byte = 1'b1;
				cmd.status   = ST_PASS;
			end
			PH_CHUNK: begin
				if (!hdr_cnt_q[2])
					id_d = {id_q[23:0], in_byte};
				else
					size_d = {in_byte, size_q[31:8]};
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == CHUNK_HDR_LAST) begin
					rem_d = size_d;
					if (id_q == ID_DATA) begin
						pad_d      = 1'b0;
						phase_d    = (size_d == '0) ? PH_DONE : PH_DATA;
						cmd.status = (size_d == '0) ? ST_COMPLETE : ST_TRUNC;
					end else begin
						pad_d   = size_d[0];
						phase_d = (size_d == '0) ? PH_CHUNK : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (rem_q != '0)
					rem_d = rem_dec;
				else
					pad_d = 1'b0;
				if ((rem_d == '0) && !pad_d)
					phase_d = PH_CHUNK;
			end
			PH_DATA: begin
				cmd.has_byte = 1'b1;
				if (rem_q != '0)
					rem_d = rem_dec;
				if (rem_d == '0) begin
					phase_d    = PH_DONE;
					cmd.status = ST_COMPLETE;
				end else begin
					cmd.status = ST_TRUNC;
				end
			end
			PH_DONE: begin
				cmd.status = ST_COMPLETE;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
		if (in_last) begin
			// end of file: back to the reset state for the next file
			cmd.has_end = 1'b1;
			phase_d     = PH_HEADER;
			held_cnt_d  = '0;
			hdr_cnt_d   = '0;
			id_d        = '0;
			size_d      = '0;
			rem_d       = '0;
			pad_d       = 1'b0;
		end
	end

	assign q_cmd  = cmd;
	assign q_push = acc && (cmd.replay || cmd.has_byte || cmd.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			held_cnt_q <= '0;
			hdr_cnt_q  <= '0;
			id_q       <= '0;
			size_q     <= '0;
			rem_q      <= '0;
			pad_q      <= 1'b0;
			busy_q     <= 1'b0;
		end else begin
			if (acc) begin
				phase_q    <= phase_d;
				held_cnt_q <= held_cnt_d;
				hdr_cnt_q  <= hdr_cnt_d;
				id_q       <= id_d;
				size_q     <= size_d;
				rem_q      <= rem_d;
				pad_q      <= pad_d;
			end
			// held bytes stay frozen until the back has replayed them
			if (q_push && cmd.replay)
				busy_q <= 1'b1;
			else if (bk.replay_done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && held_we)
			held_q[held_cnt_q] <= in_byte;
	end

endmodule

// ===== design/wdce_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdce_back
// expands queued commands into result words, one per cycle unless stalled
// ----------------------------------------------------------------------------
module wdce_back import wdce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head,
	output logic       pop,
	output bk_ctl_t    bk,
	input  logic [7:0] held_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       kind,
	output logic [1:0] end_status,
	output logic       run_last
);

	logic [3:0] idx_q;
	logic [3:0] n_data;
	logic       is_data, at_last_data, last_item, issue;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       kind_q, run_last_q;
	logic [1:0] status_q;

	// data words first (replayed header or one byte), then the end word
	assign n_data       = head.replay ? head.cnt : {3'b000, head.has_byte};
	assign is_data      = (idx_q < n_data);
	assign at_last_data = (idx_q == n_data - 4'd1);
	assign last_item    = is_data ? (at_last_data && !head.has_end) : 1'b1;
	assign issue        = head_valid && (!out_valid_q || out_ready);
	assign pop          = issue && last_item;

	assign bk.rd_idx      = idx_q;
	assign bk.replay_done = issue && head.replay && is_data && at_last_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue)
				idx_q <= last_item ? 4'd0 : idx_q + 4'd1;
			if (issue)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			byte_q     <= is_data ? (head.replay ? held_data : head.data) : 8'd0;
			kind_q     <= is_data ? KIND_BYTE : KIND_END;
			status_q   <= is_data ? ST_COMPLETE : head.status;
			run_last_q <= last_item;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign kind       = kind_q;
	assign end_status = status_q;
	assign run_last   = run_last_q;

endmodule

// ===== design/wav_data_chunk_extractor_top.sv =====
`timescale 1ns / 1ps
// a result word passes through the command queue and then the sequencer's output register
// throughput: one byte per cycle in and one word per cycle out, both unless stalled
// a header replay sends up to 12 words, one per cycle unless stalled; the next file's
// header bytes wait until the back end has issued the last word of that replay
// reset: arst_n clears phase, counters, queue and output valid at once
// ----------------------------------------------------------------------------
// wav_data_chunk_extractor_top
// pulls the payload of the first data chunk out of a riff/wave byte stream
// ----------------------------------------------------------------------------
module wav_data_chunk_extractor_top import wdce_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input word stream
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// result word stream
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       kind,
	output logic [1:0] end_status,
	output logic       run_last
);

	// command path from parser to sequencer
	logic       q_push, q_full, q_pop, q_head_valid;
	cmd_t       q_cmd, q_head;
	// held header bytes read back by the sequencer during a replay
	bk_ctl_t    bk;
	logic [7:0] held_data;

	// front: parses each byte, keeps the 12 header bytes, decides what to emit
	wdce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_push    (q_push),
		.q_cmd     (q_cmd),
		.q_full    (q_full),
		.bk        (bk),
		.held_data (held_data)
	);

	// short queue so a stalled output does not stop parsing right away
	wdce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.din        (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// back: turns each command into replay, byte and end words with run_last
	wdce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.bk         (bk),
		.held_data  (held_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.end_status (end_status),
		.run_last   (run_last)
	);

endmodule

// ===== design/wdce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdce_checker
// port level checks on the result stream of the extractor
// ----------------------------------------------------------------------------
module wdce_checker import wdce_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       kind,
	input logic [1:0] end_status,
	input logic       run_last
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_byte, kind, end_status, run_last}))
		else $error("result word changed while stalled");

	// an end word always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_END) |-> run_last)
		else $error("end word without run_last");

	// byte words carry no status
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_BYTE) |-> (end_status == ST_COMPLETE))
		else $error("byte word with nonzero status");

	// end words carry a zero byte
	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_END) |-> (out_byte == 8'd0))
		else $error("end word with nonzero byte");

endmodule

bind wav_data_chunk_extractor_top wdce_checker u_wdce_checker (.*);

// ===== tb/sv/wav_data_chunk_extractor_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_data_chunk_extractor_top_test
// streams short riff/wave files, broken ones among them, through the
// extractor with random idling on both sides, and checks every result word
// against a byte-level model of the chunk parser kept in a scoreboard class
// ----------------------------------------------------------------------------
module wav_data_chunk_extractor_top_test;
	import wdce_pkg::*;

	// idle cycles with no word moving on either side before the run is abandoned;
	// covers the long receiver hold, the longest sender gap and the end drain
	localparam int STALL_LIMIT  = 5000;
	// rough input budget for the random part
	localparam int BYTE_BUDGET  = 430;
	// receiver hold that fills the block and backs up the input
	localparam int HOLD_CYCLES  = 400;
	// chunk ids used as filler chunks
	localparam logic [31:0] ID_FMT  = 32'h666D_7420;
	localparam logic [31:0] ID_LIST = 32'h4C49_5354;

	// one result word as seen on the output side
	typedef struct packed {
		logic [7:0] out_byte;
		logic       kind;
		logic [1:0] end_status;
		logic       run_last;
	} result_word_t;

	// ------------------------------------------------------------------------
	// chunk parser model and store of expected result words
	// ------------------------------------------------------------------------
	class wav_payload_scoreboard;
		phase_t       parse_phase;
		logic [7:0]   hdr_bytes [HDR_LEN];
		logic [3:0]   hdr_cnt;
		logic [31:0]  id_shift;
		logic [31:0]  size_acc;
		logic [31:0]  left_cnt;
		logic         pad_due;
		result_word_t step_q[$];
		result_word_t want_q[$];
		int unsigned  mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			parse_phase = PH_HEADER;
			hdr_cnt     = '0;
			id_shift    = '0;
			size_acc    = '0;
			left_cnt    = '0;
			pad_due     = 1'b0;
		endfunction

		// four held bytes, first one in the top bits
		function logic [31:0] hdr_word(int at);
			return {hdr_bytes[at], hdr_bytes[at + 1], hdr_bytes[at + 2], hdr_bytes[at + 3]};
		endfunction

		function void add_word(logic [7:0] b, logic k, logic [1:0] st);
			result_word_t w;
			w.out_byte   = b;
			w.kind       = k;
			w.end_status = st;
			w.run_last   = 1'b0;
			step_q.push_back(w);
		endfunction

		function void replay_header();
			for (int i = 0; i < hdr_cnt; i++)
				add_word(hdr_bytes[i], KIND_BYTE, ST_COMPLETE);
		endfunction

		function int pending_count();
			return want_q.size();
		endfunction

		// one accepted input byte: advance the parser, queue what it emits
		function void note_byte(logic [7:0] b, logic last);
			logic [1:0] status;
			status = ST_NODATA;
			step_q.delete();
			case (parse_phase)
				PH_HEADER: begin
					if (hdr_cnt < HDR_LEN) begin
						hdr_bytes[hdr_cnt] = b;
						hdr_cnt++;
					end
					if (hdr_cnt >= HDR_LEN) begin
						// bytes 0-3 and 8-11 hold the riff and wave tags
						if (hdr_word(0) == ID_RIFF && hdr_word(8) == ID_WAVE) begin
							parse_phase = PH_CHUNK;
							hdr_cnt     = '0;
						end else begin
							replay_header();
							parse_phase = PH_PASS;
							status      = ST_PASS;
						end
					end else if (last) begin
						replay_header();
						status = ST_PASS;
					end
				end
				PH_PASS: begin
					add_word(b, KIND_BYTE, ST_COMPLETE);
					status = ST_PASS;
				end
				PH_CHUNK: begin
					if (hdr_cnt < 4)
						id_shift = {id_shift[23:0], b};
					else
						size_acc = {b, size_acc[31:8]};
					if (hdr_cnt == 4'(CHUNK_HDR_LAST)) begin
						hdr_cnt  = '0;
						left_cnt = size_acc;
						if (id_shift == ID_DATA) begin
							pad_due     = 1'b0;
							parse_phase = (left_cnt == 0) ? PH_DONE : PH_DATA;
							status      = (left_cnt == 0) ? ST_COMPLETE : ST_TRUNC;
						end else begin
							pad_due     = size_acc[0];
							parse_phase = (left_cnt == 0) ? PH_CHUNK : PH_SKIP;
						end
					end else begin
						hdr_cnt++;
					end
				end
				PH_SKIP: begin
					if (left_cnt != 0)
						left_cnt--;
					else
						pad_due = 1'b0;
					if (left_cnt == 0 && !pad_due)
						parse_phase = PH_CHUNK;
				end
				PH_DATA: begin
					add_word(b, KIND_BYTE, ST_COMPLETE);
					if (left_cnt != 0)
						left_cnt--;
					if (left_cnt == 0)
						parse_phase = PH_DONE;
					status = (left_cnt == 0) ? ST_COMPLETE : ST_TRUNC;
				end
				default: begin
					parse_phase = PH_DONE;
					status      = ST_COMPLETE;
				end
			endcase
			if (last) begin
				add_word(8'h00, KIND_END, status);
				restart();
			end
			if (step_q.size() > 0) begin
				step_q[step_q.size() - 1].run_last = 1'b1;
				foreach (step_q[i])
					want_q.push_back(step_q[i]);
			end
		endfunction

		// one accepted result word against the oldest expectation
		function void check_word(logic [7:0] got_byte, logic got_kind, logic [1:0] got_status,
				logic got_last);
			result_word_t want;
			if (want_q.size() == 0) begin
				$error("unexpected result word: out_byte %02h kind %0d end_status %0d run_last %0d",
					got_byte, got_kind, got_status, got_last);
				mismatches++;
				return;
			end
			want = want_q.pop_front();
			if (got_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got_byte);
				mismatches++;
			end
			if (got_kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got_kind);
				mismatches++;
			end
			if (got_status !== want.end_status) begin
				$error("end_status: expected %0d, got %0d", want.end_status, got_status);
				mismatches++;
			end
			if (got_last !== want.run_last) begin
				$error("run_last: expected %0d, got %0d", want.run_last, got_last);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block under test
	// ------------------------------------------------------------------------
	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       kind;
	logic [1:0] end_status;
	logic       run_last;

	wav_data_chunk_extractor_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.end_status (end_status),
		.run_last   (run_last)
	);

	wav_payload_scoreboard sb = new();

	logic [7:0] file_q[$];      // bytes of the file being sent
	int         bytes_sent;
	int         idle_cycles  = 0;
	int         rx_stall     = 0;
	int         rx_quiet     = 0;
	int         rx_hold      = 0;
	bit         rx_hold_done = 1'b0;
	bit         rx_hold_req  = 1'b0;

	always #6 clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ids go out first byte first, sizes little-endian
	function automatic void push_be32(logic [31:0] v);
		file_q.push_back(v[31:24]);
		file_q.push_back(v[23:16]);
		file_q.push_back(v[15:8]);
		file_q.push_back(v[7:0]);
	endfunction

	function automatic void push_le32(logic [31:0] v);
		file_q.push_back(v[7:0]);
		file_q.push_back(v[15:8]);
		file_q.push_back(v[23:16]);
		file_q.push_back(v[31:24]);
	endfunction

	function automatic void push_random(int n);
		repeat (n) file_q.push_back(8'($urandom));
	endfunction

	function automatic void trim_file(int n);
		if (file_q.size() > n)
			file_q = file_q[0:n - 1];
	endfunction

	// random file: mostly well-formed wave files with random content, some cut at
	// a random byte, the rest short files and bad headers
	function automatic void build_file();
		int          shape;
		int          n;
		int          chunks;
		bit          runaway;
		logic [31:0] id;
		logic [31:0] size;
		file_q.delete();
		shape = $urandom_range(0, 99);
		if (shape < 10) begin
			// short file, sometimes with a riff tag in front
			n = $urandom_range(1, HDR_LEN - 1);
			if ($urandom_range(0, 1))
				push_be32(ID_RIFF);
			push_random(HDR_LEN);
			trim_file(n);
		end else if (shape < 22) begin
			// bad header followed by bytes that pass straight through
			if ($urandom_range(0, 1)) begin
				push_be32(ID_RIFF);
				push_le32($urandom);
				push_be32(ID_WAVE ^ (32'd1 << $urandom_range(0, 31)));
			end else begin
				push_be32(ID_RIFF ^ (32'd1 << $urandom_range(0, 31)));
				push_le32($urandom);
				push_be32($urandom_range(0, 1) ? ID_WAVE : $urandom);
			end
			push_random($urandom_range(0, 8));
		end else begin
			push_be32(ID_RIFF);
			push_le32($urandom);
			push_be32(ID_WAVE);
			chunks  = $urandom_range(0, 2);
			runaway = 1'b0;
			for (int i = 0; i < chunks && !runaway; i++) begin
				case ($urandom_range(0, 3))
					0:       id = ID_FMT;
					1:       id = ID_LIST;
					2:       id = $urandom;
					default: id = ID_DATA ^ (32'd1 << $urandom_range(0, 31));
				endcase
				push_be32(id);
				if ($urandom_range(0, 9) == 0) begin
					// chunk that claims more than the file holds
					size    = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
					runaway = 1'b1;
					push_le32(size);
					push_random($urandom_range(0, 5));
				end else begin
					size = $urandom_range(0, 6);
					push_le32(size);
					push_random(int'(size + size[0]));
				end
			end
			if (!runaway && $urandom_range(0, 6) != 0) begin
				push_be32(ID_DATA);
				if ($urandom_range(0, 4) == 0) begin
					// full 32-bit size, usually far beyond the file end
					size = $urandom;
					push_le32(size);
					push_random($urandom_range(1, 10));
				end else begin
					// payload then a few trailing bytes that get dropped
					size = $urandom_range(0, 10);
					push_le32(size);
					push_random(int'(size + $urandom_range(0, 4)));
				end
			end
			if ($urandom_range(0, 3) == 0)
				trim_file($urandom_range(1, file_q.size()));
		end
	endfunction

	// offer one word and hold it until taken, then maybe idle
	task automatic send_word(input logic [7:0] b, input logic last, input bit steady);
		int gap;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b, last);
		bytes_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_file(input bit steady);
		foreach (file_q[i])
			send_word(file_q[i], i == file_q.size() - 1, steady);
	endtask

	// sender lowers valid and waits for every expected word to come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_count() != 0);
	endtask

	// ------------------------------------------------------------------------
	// receiver: checks accepted words and drives out_ready
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_word(out_byte, kind, end_status, run_last);
			if (rx_hold > 0) begin
				// long hold: the block fills up and stalls its input
				rx_hold--;
				out_ready <= 1'b0;
			end else if (!rx_hold_done && rx_hold_req) begin
				rx_hold_done = 1'b1;
				rx_hold      = HOLD_CYCLES;
				out_ready   <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				// quiet stretches with no stalls at all
				if (rx_quiet > 0)
					rx_quiet--;
				else if ($urandom_range(0, 39) == 0)
					rx_quiet = $urandom_range(30, 120);
				else if ($urandom_range(0, 2) == 0)
					rx_stall = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long with no word moving on either side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int files;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_byte      = 8'h00;
		in_last      = 1'b0;
		bytes_sent   = 0;
		files        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte file, all ones: replayed, then passthrough end
		file_q.delete();
		file_q.push_back(8'hFF);
		send_file(1'b1);

		// wave tag off by one bit: header replayed, later bytes passed
		file_q.delete();
		push_be32(ID_RIFF);
		push_le32(32'h0000_0024);
		push_be32(ID_WAVE ^ 32'h0000_0001);
		file_q.push_back(8'h00);
		file_q.push_back(8'h5A);
		send_file(1'b0);

		// valid header that ends the file: no data chunk
		file_q.delete();
		push_be32(ID_RIFF);
		push_le32(32'h0000_0004);
		push_be32(ID_WAVE);
		send_file(1'b0);

		// empty data chunk with a trailing byte that is dropped
		file_q.delete();
		push_be32(ID_RIFF);
		push_le32(32'h0000_000D);
		push_be32(ID_WAVE);
		push_be32(ID_DATA);
		push_le32(32'h0000_0000);
		file_q.push_back(8'hC3);
		send_file(1'b0);
		drain_results();

		// long data chunk sent with no gaps while the receiver holds off
		file_q.delete();
		push_be32(ID_RIFF);
		push_le32(32'h0000_0044);
		push_be32(ID_WAVE);
		push_be32(ID_DATA);
		push_le32(32'h0000_0030);
		push_random(48);
		rx_hold_req = 1'b1;
		send_file(1'b1);
		drain_results();

		// random files, some sent back to back, with a full drain now and then
		while (bytes_sent < BYTE_BUDGET) begin
			build_file();
			send_file($urandom_range(0, 3) == 0);
			files++;
			if (files % 5 == 0)
				drain_results();
		end

		// drain, then let the pipeline settle
		drain_results();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_count() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/wdce_pkg.sv
design/wdce_queue.sv
design/wdce_front.sv
design/wdce_back.sv
design/wav_data_chunk_extractor_top.sv
design/wdce_checker.sv
tb/sv/wav_data_chunk_extractor_top_test.sv
